// ===== hw/rtl/mgdtl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgdtl_pkg
// Shared constants and types of the motion gated dark target locator: field
// widths, frame limits, register indexes and reset values.
// ----------------------------------------------------------------------------
package mgdtl_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned PosW     = 10;
  localparam int unsigned LimitW   = 20;
  localparam int unsigned CountW   = 21;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  localparam int unsigned MaxRows = 1024;
  localparam int unsigned MaxCols = 1024;
  localparam int unsigned RowW    = $clog2(MaxRows);
  localparam int unsigned ColW    = $clog2(MaxCols);

  localparam logic [RowW-1:0]   RowLast  = RowW'(MaxRows - 1);
  localparam logic [ColW-1:0]   ColLast  = ColW'(MaxCols - 1);
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [PixW-1:0]   DiffThresholdRst = PixW'(20);
  localparam logic [LimitW-1:0] MotionLimitRst   = LimitW'(1000);
  localparam logic [PixW-1:0]   DarkLevelRst     = PixW'(70);
  localparam logic [PosW-1:0]   LockRadiusRst    = PosW'(5);
  localparam logic [PosW-1:0]   TargetColRst     = PosW'(235);
  localparam logic [PosW-1:0]   TargetRowRst     = PosW'(235);

  typedef enum logic [CfgIdxW-1:0] {
    RegDiffThreshold = 3'd0,
    RegMotionLimit   = 3'd1,
    RegDarkLevel     = 3'd2,
    RegLockRadius    = 3'd3,
    RegTargetCol     = 3'd4,
    RegTargetRow     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0] cur_blue;
    logic [PixW-1:0] cur_green;
    logic [PixW-1:0] cur_red;
    logic [PixW-1:0] prev_blue;
    logic [PixW-1:0] prev_green;
    logic [PixW-1:0] prev_red;
    logic            end_of_line;
    logic            end_of_frame;
  } pixel_t;

  typedef struct packed {
    logic            motion;
    logic [PosW-1:0] first_row;
    logic [PosW-1:0] first_col;
    logic [PosW-1:0] last_row;
    logic [PosW-1:0] last_col;
    logic [PosW-1:0] mid_row;
    logic [PosW-1:0] mid_col;
    logic            locked;
  } result_t;

  function automatic logic [PixW-1:0] abs_diff8(logic [PixW-1:0] a, logic [PixW-1:0] b);
    abs_diff8 = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [PosW-1:0] abs_diff10(logic [PosW-1:0] a, logic [PosW-1:0] b);
    abs_diff10 = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== hw/rtl/motion_gated_dark_target_locator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_gated_dark_target_locator
// Per-frame motion count and dark target extents over a raster pixel stream.
//
// One pixel enters per transfer on the input channel (in_valid_i/in_stall_o)
// with current and previous frame BGR bytes and end of line / end of frame
// marks. Pixels land in an input register; once the output side advances,
// the pixel updates the row and column counters, the changed pixel count
// and the dark extents. On an end of frame pixel one result is loaded into
// the output register and offered on the output channel (out_valid_o/
// out_stall_i). The first frame after reset gives no result.
// Throughput is one pixel per cycle while the receiver does not stall; the
// single stage between the input register and the output register sets it.
// When the receiver stalls with a result pending, the stage holds and the
// input register fills, then in_stall_o rises until the result is taken.
// Reset clears the counters, extents and both valid flags and loads the
// register defaults. Registers are written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i; the user writes only while no pixel is in flight (not enforced).
// ----------------------------------------------------------------------------
module motion_gated_dark_target_locator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mgdtl_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mgdtl_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mgdtl_pkg::PixW-1:0]        cur_blue_i,
  input  logic [mgdtl_pkg::PixW-1:0]        cur_green_i,
  input  logic [mgdtl_pkg::PixW-1:0]        cur_red_i,
  input  logic [mgdtl_pkg::PixW-1:0]        prev_blue_i,
  input  logic [mgdtl_pkg::PixW-1:0]        prev_green_i,
  input  logic [mgdtl_pkg::PixW-1:0]        prev_red_i,
  input  logic                              end_of_line_i,
  input  logic                              end_of_frame_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              motion_o,
  output logic [mgdtl_pkg::PosW-1:0]        first_row_o,
  output logic [mgdtl_pkg::PosW-1:0]        first_col_o,
  output logic [mgdtl_pkg::PosW-1:0]        last_row_o,
  output logic [mgdtl_pkg::PosW-1:0]        last_col_o,
  output logic [mgdtl_pkg::PosW-1:0]        mid_row_o,
  output logic [mgdtl_pkg::PosW-1:0]        mid_col_o,
  output logic                              locked_o
);

  import mgdtl_pkg::*;

  // configuration
  logic [PixW-1:0]   diff_threshold_q;
  logic [LimitW-1:0] motion_limit_q;
  logic [PixW-1:0]   dark_level_q;
  logic [PosW-1:0]   lock_radius_q;
  logic [PosW-1:0]   target_col_q;
  logic [PosW-1:0]   target_row_q;

  // pipeline
  logic    pix_valid_q;
  pixel_t  pix_q;
  logic    out_valid_q;
  result_t out_q, out_d;
  logic    advance;
  logic    in_xfer;

  // frame state
  logic              ref_ready_q, ref_ready_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [CountW-1:0] count_q, count_d;
  logic              dark_seen_q, dark_seen_d;
  logic [PosW-1:0]   first_row_q, first_row_d;
  logic [PosW-1:0]   first_col_q, first_col_d;
  logic [PosW-1:0]   last_row_q, last_row_d;
  logic [PosW-1:0]   last_col_q, last_col_d;

  logic              changed;
  logic              dark;
  logic              motion;
  logic [PosW:0]     sum_row;
  logic [PosW:0]     sum_col;
  logic [PosW-1:0]   mid_row;
  logic [PosW-1:0]   mid_col;
  logic              emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_threshold_q <= DiffThresholdRst;
      motion_limit_q   <= MotionLimitRst;
      dark_level_q     <= DarkLevelRst;
      lock_radius_q    <= LockRadiusRst;
      target_col_q     <= TargetColRst;
      target_row_q     <= TargetRowRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDiffThreshold: diff_threshold_q <= cfg_wdata_i[PixW-1:0];
        RegMotionLimit:   motion_limit_q   <= cfg_wdata_i[LimitW-1:0];
        RegDarkLevel:     dark_level_q     <= cfg_wdata_i[PixW-1:0];
        RegLockRadius:    lock_radius_q    <= cfg_wdata_i[PosW-1:0];
        RegTargetCol:     target_col_q     <= cfg_wdata_i[PosW-1:0];
        RegTargetRow:     target_row_q     <= cfg_wdata_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = pix_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (in_xfer) begin
      pix_valid_q <= 1'b1;
    end else if (advance) begin
      pix_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pix_q <= '{cur_blue:     cur_blue_i,
                 cur_green:    cur_green_i,
                 cur_red:      cur_red_i,
                 prev_blue:    prev_blue_i,
                 prev_green:   prev_green_i,
                 prev_red:     prev_red_i,
                 end_of_line:  end_of_line_i,
                 end_of_frame: end_of_frame_i};
    end
  end

  // per pixel update
  always_comb begin
    changed = (abs_diff8(pix_q.cur_red, pix_q.prev_red) > diff_threshold_q) &&
              (abs_diff8(pix_q.cur_blue, pix_q.prev_blue) > diff_threshold_q) &&
              (abs_diff8(pix_q.cur_green, pix_q.prev_green) > diff_threshold_q);
    dark    = (pix_q.cur_blue < dark_level_q) && (pix_q.cur_green < dark_level_q) &&
              (pix_q.cur_red < dark_level_q);

    count_d = (changed && count_q != CountMax) ? count_q + 1'b1 : count_q;

    dark_seen_d = dark_seen_q;
    first_row_d = first_row_q;
    first_col_d = first_col_q;
    last_row_d  = last_row_q;
    last_col_d  = last_col_q;
    if (dark) begin
      if (!dark_seen_q) begin
        dark_seen_d = 1'b1;
        first_row_d = PosW'(row_q);
        first_col_d = PosW'(col_q);
      end
      last_row_d = PosW'(row_q);
      last_col_d = PosW'(col_q);
    end

    motion  = count_d > CountW'(motion_limit_q);
    sum_row = {1'b0, first_row_d} + {1'b0, last_row_d};
    sum_col = {1'b0, first_col_d} + {1'b0, last_col_d};
    mid_row = sum_row[PosW:1];
    mid_col = sum_col[PosW:1];

    out_d = '0;
    out_d.motion = motion;
    if (!motion) begin
      out_d.first_row = first_row_d;
      out_d.first_col = first_col_d;
      out_d.last_row  = last_row_d;
      out_d.last_col  = last_col_d;
      out_d.mid_row   = mid_row;
      out_d.mid_col   = mid_col;
      out_d.locked    = (abs_diff10(mid_col, target_col_q) < lock_radius_q) &&
                        (abs_diff10(mid_row, target_row_q) < lock_radius_q);
    end

    emit        = pix_q.end_of_frame && ref_ready_q;
    ref_ready_d = ref_ready_q;
    row_d       = row_q;
    col_d       = col_q;
    if (pix_q.end_of_frame) begin
      ref_ready_d = 1'b1;
      row_d       = '0;
      col_d       = '0;
      count_d     = '0;
      dark_seen_d = 1'b0;
      first_row_d = '0;
      first_col_d = '0;
      last_row_d  = '0;
      last_col_d  = '0;
    end else if (pix_q.end_of_line) begin
      col_d = '0;
      if (row_q != RowLast) begin
        row_d = row_q + 1'b1;
      end
    end else if (col_q != ColLast) begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_ready_q <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      count_q     <= '0;
      dark_seen_q <= 1'b0;
      first_row_q <= '0;
      first_col_q <= '0;
      last_row_q  <= '0;
      last_col_q  <= '0;
    end else if (pix_valid_q && advance) begin
      ref_ready_q <= ref_ready_d;
      row_q       <= row_d;
      col_q       <= col_d;
      count_q     <= count_d;
      dark_seen_q <= dark_seen_d;
      first_row_q <= first_row_d;
      first_col_q <= first_col_d;
      last_row_q  <= last_row_d;
      last_col_q  <= last_col_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= pix_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pix_valid_q && emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign motion_o    = out_q.motion;
  assign first_row_o = out_q.first_row;
  assign first_col_o = out_q.first_col;
  assign last_row_o  = out_q.last_row;
  assign last_col_o  = out_q.last_col;
  assign mid_row_o   = out_q.mid_row;
  assign mid_col_o   = out_q.mid_col;
  assign locked_o    = out_q.locked;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for motion_gated_dark_target_locator. Pixel frames are
// pushed through the input channel under changing register settings and
// random gaps and stalls. A scoreboard class tracks frame position, changed
// pixel count and dark extents, predicts the frame report and compares every
// report that leaves the block, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import mgdtl_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned ItemGoal     = 1550;
  localparam int unsigned SettleCycles = 8;

  class locator_scoreboard;
    logic [PixW-1:0]   diff_thr;
    logic [LimitW-1:0] motion_lim;
    logic [PixW-1:0]   dark_lvl;
    logic [PosW-1:0]   radius;
    logic [PosW-1:0]   tgt_col;
    logic [PosW-1:0]   tgt_row;
    bit                have_ref;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic [CountW-1:0] changed;
    bit                dark_seen;
    logic [PosW-1:0]   first_r, first_c, last_r, last_c;
    result_t           pending_frames[$];
    int unsigned       errors, reports, motion_frames, locked_frames, pixels;

    function new();
      diff_thr   = DiffThresholdRst;
      motion_lim = MotionLimitRst;
      dark_lvl   = DarkLevelRst;
      radius     = LockRadiusRst;
      tgt_col    = TargetColRst;
      tgt_row    = TargetRowRst;
      have_ref   = 1'b0;
      restart_frame();
    endfunction

    function void restart_frame();
      row       = '0;
      col       = '0;
      changed   = '0;
      dark_seen = 1'b0;
      first_r   = '0;
      first_c   = '0;
      last_r    = '0;
      last_c    = '0;
    endfunction

    function int unsigned span(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        RegDiffThreshold: diff_thr = v[PixW-1:0];
        RegMotionLimit: motion_lim = v[LimitW-1:0];
        RegDarkLevel: dark_lvl = v[PixW-1:0];
        RegLockRadius: radius = v[PosW-1:0];
        RegTargetCol: tgt_col = v[PosW-1:0];
        RegTargetRow: tgt_row = v[PosW-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(pixel_t p);
      result_t     r;
      int unsigned mr, mc;
      pixels++;
      if (span(p.cur_red, p.prev_red) > diff_thr && span(p.cur_blue, p.prev_blue) > diff_thr &&
          span(p.cur_green, p.prev_green) > diff_thr) begin
        if (changed != CountMax) changed++;
      end
      if (p.cur_blue < dark_lvl && p.cur_green < dark_lvl && p.cur_red < dark_lvl) begin
        if (!dark_seen) begin
          dark_seen = 1'b1;
          first_r   = row;
          first_c   = col;
        end
        last_r = row;
        last_c = col;
      end
      if (p.end_of_frame) begin
        if (have_ref) begin
          r        = '0;
          r.motion = (changed > motion_lim);
          if (!r.motion) begin
            mr          = (int'(first_r) + int'(last_r)) / 2;
            mc          = (int'(first_c) + int'(last_c)) / 2;
            r.first_row = first_r;
            r.first_col = first_c;
            r.last_row  = last_r;
            r.last_col  = last_c;
            r.mid_row   = PosW'(mr);
            r.mid_col   = PosW'(mc);
            r.locked    = (span(mc, tgt_col) < radius) && (span(mr, tgt_row) < radius);
          end
          if (r.motion) motion_frames++;
          if (r.locked) locked_frames++;
          pending_frames = {pending_frames, r};
        end
        have_ref = 1'b1;
        restart_frame();
      end else if (p.end_of_line) begin
        col = '0;
        if (row != RowLast) row++;
      end else if (col != ColLast) begin
        col++;
      end
    endfunction

    function void field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_frames.size() == 0) begin
        errors++;
        $display("%0t: report with no frame pending: expected none, actual %p", $time, got);
        return;
      end
      want = pending_frames.pop_front();
      reports++;
      field("motion", want.motion, got.motion);
      field("first_row", want.first_row, got.first_row);
      field("first_col", want.first_col, got.first_col);
      field("last_row", want.last_row, got.last_row);
      field("last_col", want.last_col, got.last_col);
      field("mid_row", want.mid_row, got.mid_row);
      field("mid_col", want.mid_col, got.mid_col);
      field("locked", want.locked, got.locked);
    endfunction
  endclass

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  cfg_reg_e            cfg_idx   = RegDiffThreshold;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  pixel_t              pix       = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                motion, locked;
  logic [PosW-1:0]     first_row, first_col, last_row, last_col, mid_row, mid_col;

  locator_scoreboard sb;
  int unsigned       idle_pct  = 0;
  int unsigned       stall_pct = 0;
  int unsigned       cycles    = 0;
  int unsigned       settings  = 0;

  motion_gated_dark_target_locator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cur_blue_i    (pix.cur_blue),
    .cur_green_i   (pix.cur_green),
    .cur_red_i     (pix.cur_red),
    .prev_blue_i   (pix.prev_blue),
    .prev_green_i  (pix.prev_green),
    .prev_red_i    (pix.prev_red),
    .end_of_line_i (pix.end_of_line),
    .end_of_frame_i(pix.end_of_frame),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .motion_o      (motion),
    .first_row_o   (first_row),
    .first_col_o   (first_col),
    .last_row_o    (last_row),
    .last_col_o    (last_col),
    .mid_row_o     (mid_row),
    .mid_col_o     (mid_col),
    .locked_o      (locked)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // a report transfer happens at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && out_stall == 1'b0) begin
      sb.check_result({motion, first_row, first_col, last_row, last_col, mid_row, mid_col,
                       locked});
    end
  end

  task automatic write_reg(cfg_reg_e idx, int unsigned v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CfgDataW'(v);
    sb.set_reg(idx, CfgDataW'(v));
    @(posedge clk_i);
  endtask

  task automatic send_pixel(pixel_t p);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    pix      <= p;
    do @(negedge clk_i); while (in_stall !== 1'b0);
    sb.note_pixel(p);
    @(posedge clk_i);
  endtask

  task automatic drain_results(int unsigned settle);
    in_valid <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  function automatic pixel_t mk(int unsigned cb, cg, cr, pb, pg, pr, bit eol, bit eof);
    pixel_t p;
    p.cur_blue     = PixW'(cb);
    p.cur_green    = PixW'(cg);
    p.cur_red      = PixW'(cr);
    p.prev_blue    = PixW'(pb);
    p.prev_green   = PixW'(pg);
    p.prev_red     = PixW'(pr);
    p.end_of_line  = eol;
    p.end_of_frame = eof;
    return p;
  endfunction

  function automatic pixel_t make_pixel(int unsigned dark_pct, int unsigned chg_pct);
    pixel_t          p;
    logic [PixW-1:0] lvl;
    lvl = sb.dark_lvl;
    p   = mk($urandom_range(255), $urandom_range(255), $urandom_range(255),
             $urandom_range(255), $urandom_range(255), $urandom_range(255), 1'b0, 1'b0);
    if (lvl != 0 && $urandom_range(99) < dark_pct) begin
      p.cur_blue  = PixW'($urandom_range(lvl - 1));
      p.cur_green = PixW'($urandom_range(lvl - 1));
      p.cur_red   = PixW'($urandom_range(lvl - 1));
    end
    if ($urandom_range(99) < chg_pct) begin
      p.prev_blue  = p.cur_blue ^ 8'h80;
      p.prev_green = p.cur_green ^ 8'h80;
      p.prev_red   = p.cur_red ^ 8'h80;
    end else if ($urandom_range(1) == 0) begin
      p.prev_blue  = p.cur_blue;
      p.prev_green = p.cur_green;
      p.prev_red   = p.cur_red;
    end
    return p;
  endfunction

  task automatic send_frame(int unsigned n_rows, int unsigned n_cols, int unsigned eol_pct);
    pixel_t      p;
    int unsigned dark_pct, chg_pct;
    dark_pct = $urandom_range(60);
    chg_pct  = $urandom_range(100);
    for (int unsigned r = 0; r < n_rows; r++) begin
      for (int unsigned c = 0; c < n_cols; c++) begin
        p                = make_pixel(dark_pct, chg_pct);
        p.end_of_frame   = (r == n_rows - 1) && (c == n_cols - 1);
        p.end_of_line    = (c == n_cols - 1) &&
                           (p.end_of_frame ? ($urandom_range(1) == 1)
                                           : ($urandom_range(99) < eol_pct));
        send_pixel(p);
      end
    end
  endtask

  // one row longer than the column range
  task automatic send_strip();
    pixel_t      p;
    int unsigned v;
    for (int unsigned i = 0; i < 1040; i++) begin
      v = (i == 0 || i >= 1020) ? 5 : 200;
      p = mk(v, v, v, $urandom_range(255), $urandom_range(255), $urandom_range(255),
             1'b0, i == 1039);
      send_pixel(p);
    end
  endtask

  function automatic int unsigned pick(int unsigned sel, int unsigned top, int unsigned lo,
                                       int unsigned hi);
    case (sel % 4)
      0: return 0;
      1: return top;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  initial begin
    pixel_t      p;
    int unsigned kind;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reference frame, no report
    send_pixel(mk(255, 255, 255, 0, 0, 0, 1'b0, 1'b0));
    send_pixel(mk(0, 0, 0, 255, 255, 255, 1'b1, 1'b0));
    send_pixel(mk(69, 69, 69, 70, 70, 70, 1'b0, 1'b0));
    send_pixel(mk(70, 70, 70, 49, 49, 49, 1'b0, 1'b1));
    // threshold and dark level boundaries over two rows
    send_pixel(mk(100, 100, 100, 120, 120, 120, 1'b0, 1'b0));
    send_pixel(mk(69, 0, 0, 90, 21, 21, 1'b0, 1'b0));
    send_pixel(mk(70, 0, 0, 91, 21, 21, 1'b1, 1'b0));
    send_pixel(mk(0, 69, 0, 0, 0, 0, 1'b0, 1'b0));
    send_pixel(mk(200, 200, 200, 0, 0, 0, 1'b0, 1'b0));
    send_pixel(mk(0, 0, 69, 255, 255, 255, 1'b1, 1'b1));
    // no dark pixel, frame ends without end of line
    send_pixel(mk(255, 255, 255, 255, 255, 255, 1'b0, 1'b0));
    send_pixel(mk(128, 128, 128, 0, 0, 0, 1'b0, 1'b1));
    drain_results(SettleCycles);

    write_reg(RegDiffThreshold, 0);
    write_reg(RegMotionLimit, 0);
    write_reg(RegLockRadius, 1);
    write_reg(RegTargetCol, 1);
    write_reg(RegTargetRow, 0);
    cfg_we <= 1'b0;
    settings++;
    // still frame locked on target, then a one pixel motion frame
    send_pixel(mk(10, 10, 10, 10, 10, 10, 1'b0, 1'b0));
    send_pixel(mk(10, 10, 10, 10, 10, 10, 1'b0, 1'b0));
    send_pixel(mk(50, 50, 50, 50, 50, 50, 1'b1, 1'b1));
    send_pixel(mk(0, 0, 0, 1, 1, 1, 1'b1, 1'b1));
    drain_results(SettleCycles);

    // column counter saturation
    write_reg(RegDiffThreshold, 255);
    write_reg(RegMotionLimit, 1048575);
    write_reg(RegDarkLevel, 128);
    write_reg(RegLockRadius, 3);
    write_reg(RegTargetCol, 511);
    cfg_we <= 1'b0;
    settings++;
    send_strip();

    for (int unsigned phase = 0; phase < 4 || sb.pixels < ItemGoal; phase++) begin
      drain_results(SettleCycles);
      write_reg(RegDiffThreshold, pick(phase, 255, 0, 60));
      write_reg(RegMotionLimit, pick(phase + 1, 1048575, 0, 10));
      write_reg(RegDarkLevel, pick(phase + 2, 255, 20, 160));
      write_reg(RegLockRadius, pick(phase + 3, 1023, 1, 4));
      write_reg(RegTargetCol, pick(phase + 1, 1023, 0, 5));
      write_reg(RegTargetRow, pick(phase + 2, 1023, 0, 3));
      cfg_we <= 1'b0;
      settings++;
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      repeat (12) begin
        kind = $urandom_range(29);
        if (kind == 0) begin
          repeat (8) begin
            p              = make_pixel(30, 50);
            p.end_of_line  = ($urandom_range(3) == 0);
            p.end_of_frame = ($urandom_range(7) == 0);
            send_pixel(p);
          end
        end else if (kind < 4) begin
          send_frame($urandom_range(4, 1), $urandom_range(6, 1), 40);
        end else begin
          send_frame($urandom_range(4, 1), $urandom_range(6, 1), 100);
        end
        if ($urandom_range(19) == 0) drain_results(1);
      end
    end

    idle_pct = 0;
    drain_results(SettleCycles);
    $display("summary: %0d pixels in, %0d frame reports checked (%0d motion, %0d locked)",
             sb.pixels, sb.reports, sb.motion_frames, sb.locked_frames);
    $display("summary: %0d register settings, %0d mismatches", settings, sb.errors);
    if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
